### sv/ukst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ukst_pkg
// Shared codes for the unsorted key set table: opcodes, status codes and
// register indexes.
// ----------------------------------------------------------------------------
package ukst_pkg;

  // Request opcodes
  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  // Result status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Register indexes (byte address divided by four)
  localparam logic REG_CAPACITY = 1'b0;

  // Fixed field widths
  localparam int KEY_FIELD_W   = 64;
  localparam int SLOT_FIELD_W  = 6;
  localparam int COUNT_FIELD_W = 7;
  localparam int CAP_FIELD_W   = 7;

  // Reset value of capacity_in_use
  localparam logic [CAP_FIELD_W-1:0] CAPACITY_RESET = 7'd64;

endpackage

### sv/unsorted_key_set_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unsorted_key_set_table_unit
// Set of distinct keys held unsorted in a key RAM. Add, remove and find each
// scan the occupied entries in order; one result item per request item.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  s_*       in         s_tvalid / s_tready        tuser: opcode; tdata: key
//  m_*       out        m_tvalid / m_tready        tdata: found, slot_index,
//                                                  element_count, status
//  apb       in         psel / penable / pready    capacity_in_use at addr 0
//
//  An item's time is set by the single read port of the key RAM: the scan
//  reads one stored key per cycle, and a remove with a hit reads the last
//  entry once more before the write-back. One item is in work at a time.
//  Reset is synchronous; the key RAM has no clearing pass, only entries below
//  the count are ever read. The result sits in an output register, so the
//  next item is accepted while it waits; a stalled m_tready holds the block
//  only when the next result is ready.
// ----------------------------------------------------------------------------
module unsorted_key_set_table_unit
  import ukst_pkg::*;
#(
  parameter int TABLE_DEPTH = 64,
  parameter int KEY_BITS    = 64
) (
  input  logic        clk,
  input  logic        rst,
  // request item
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,    // [63:0] key
  input  logic [1:0]  s_tuser,    // [1:0] opcode
  // result item
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,    // [0] found, [6:1] slot_index,
                                  // [13:7] element_count, [14] status, [15] 0
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = ((CNT_W > CAP_FIELD_W) ? CNT_W : CAP_FIELD_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_LAST_RD,
    S_LAST_WR,
    S_DONE
  } state_t;

  state_t                 state;
  logic [CAP_FIELD_W-1:0] capacity;
  logic [CNT_W-1:0]       held_count;

  logic [1:0]             op_q;
  logic [KEY_BITS-1:0]    key_q;
  logic [CNT_W-1:0]       scan_idx;
  logic [IDX_W-1:0]       cmp_idx;
  logic                   cmp_pending;
  logic                   hit;
  logic [IDX_W-1:0]       hit_pos;
  logic                   status_q;

  logic                   out_found;
  logic [SLOT_FIELD_W-1:0]  out_slot;
  logic [COUNT_FIELD_W-1:0] out_count;
  logic                   out_status;

  // RAM ports
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [KEY_BITS-1:0]    wr_data;
  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;
  logic [KEY_BITS-1:0]    rd_data;

  logic                   match;
  logic                   more;
  logic                   room;
  logic [CNT_W-1:0]       last_count;
  logic [CMP_W-1:0]       cap_ext;
  logic [CMP_W-1:0]       cap_eff;
  logic [CMP_W-1:0]       cnt_ext;
  logic [IDX_W+SLOT_FIELD_W-1:0]  pos_wide;
  logic [CNT_W+COUNT_FIELD_W-1:0] cnt_wide;

  ukst_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(capacity) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
      capacity <= pwdata[CAP_FIELD_W-1:0];
    end
  end

  // Scan and capacity decisions
  assign match      = cmp_pending && (rd_data == key_q);
  assign more       = scan_idx < held_count;
  assign last_count = held_count - CNT_W'(1);
  assign cap_ext    = CMP_W'(capacity);
  assign cap_eff    = (cap_ext > CMP_W'(TABLE_DEPTH)) ? CMP_W'(TABLE_DEPTH) : cap_ext;
  assign cnt_ext    = CMP_W'(held_count);
  assign room       = cnt_ext < cap_eff;

  // Drive key RAM: scan reads, last-entry read, append and move writes
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = scan_idx[IDX_W-1:0];
    wr_en   = 1'b0;
    wr_addr = held_count[IDX_W-1:0];
    wr_data = key_q;
    if (state == S_SCAN && !match && more) begin
      rd_en = 1'b1;
    end
    if (state == S_LAST_RD) begin
      rd_en   = 1'b1;
      rd_addr = last_count[IDX_W-1:0];
    end
    if (state == S_APPLY && op_q == OP_ADD && !hit && room) begin
      wr_en = 1'b1;
    end
    if (state == S_LAST_WR) begin
      wr_en   = 1'b1;
      wr_addr = hit_pos;
      wr_data = rd_data;
    end
  end

  // Result field widths
  assign pos_wide = {{SLOT_FIELD_W{1'b0}}, hit_pos};
  assign cnt_wide = {{COUNT_FIELD_W{1'b0}}, held_count};

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = {1'b0, out_status, out_count, out_slot, out_found};

  // Sequencer with registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      held_count  <= '0;
      m_tvalid    <= 1'b0;
      cmp_pending <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op_q        <= s_tuser;
            key_q       <= s_tdata[KEY_BITS-1:0];
            scan_idx    <= '0;
            cmp_pending <= 1'b0;
            hit         <= 1'b0;
            hit_pos     <= '0;
            status_q    <= STATUS_OK;
            state       <= (s_tuser == OP_NONE) ? S_DONE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (match) begin
            hit         <= 1'b1;
            hit_pos     <= cmp_idx;
            cmp_pending <= 1'b0;
            state       <= S_APPLY;
          end else if (more) begin
            cmp_idx     <= scan_idx[IDX_W-1:0];
            cmp_pending <= 1'b1;
            scan_idx    <= scan_idx + CNT_W'(1);
          end else begin
            cmp_pending <= 1'b0;
            state       <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (op_q == OP_REMOVE && hit) begin
            state <= S_LAST_RD;
          end else begin
            state <= S_DONE;
          end
          if (op_q == OP_ADD && !hit) begin
            if (room) begin
              held_count <= held_count + CNT_W'(1);
            end else begin
              status_q <= STATUS_FULL;
            end
          end
        end
        S_LAST_RD: begin
          state <= S_LAST_WR;
        end
        S_LAST_WR: begin
          held_count <= last_count;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            out_found  <= hit;
            out_slot   <= pos_wide[SLOT_FIELD_W-1:0];
            out_count  <= cnt_wide[COUNT_FIELD_W-1:0];
            out_status <= status_q;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### sv/ukst_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ukst_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module ukst_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/ukst_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ukst_checker
// Port-level checks for the unsorted key set table, bound to the top level.
// ----------------------------------------------------------------------------
module ukst_checker #(
  parameter int TABLE_DEPTH = 64
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Take one request at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while one is in work");

  // Keep the count within the table
  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (TABLE_DEPTH > 127) || (m_tdata[13:7] <= 7'(TABLE_DEPTH)))
    else $error("element count above table depth");

  // Drop an add only for an absent key
  a_full_miss: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[14] |-> !m_tdata[0])
    else $error("full status on a present key");

  // Report slot zero on a miss
  a_miss_slot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[6:1] == 6'd0)
    else $error("nonzero slot on a miss");

endmodule

bind unsorted_key_set_table_unit ukst_checker #(
  .TABLE_DEPTH (TABLE_DEPTH)
) u_ukst_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### sim/unsorted_key_set_table_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unsorted_key_set_table_unit_tb
// Drives add, remove and find requests into the key set table and checks
// every result item against a local copy of the table kept in the bench.
// Covers empty and full tables, swap-on-remove, capacity limits and the
// unused opcode, then long random traffic under changing backpressure.
// ----------------------------------------------------------------------------
module unsorted_key_set_table_unit_tb;
  import ukst_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int REG_SPARE   = 1;
  localparam int POOL_SIZE   = 80;
  localparam int CYCLE_LIMIT = 1000000;

  // Result fields, highest bit of m_tdata first
  typedef struct packed {
    logic                     status;
    logic [COUNT_FIELD_W-1:0] element_count;
    logic [SLOT_FIELD_W-1:0]  slot_index;
    logic                     found;
  } table_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;    // [63:0] key
  logic [1:0]  s_tuser;    // [1:0] opcode
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;    // [0] found, [6:1] slot_index, [13:7] element_count,
                           // [14] status, [15] 0
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Local copy of the table and its register
  logic [KEY_FIELD_W-1:0]   stored_keys [TABLE_DEPTH];
  int                       held_keys = 0;
  logic [CAP_FIELD_W-1:0]   model_capacity = CAPACITY_RESET;
  table_result_t            pending_results [$];
  logic [KEY_FIELD_W-1:0]   key_pool [POOL_SIZE];

  int unsigned sender_idle_pct = 0;
  int unsigned receiver_idle_pct = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  unsorted_key_set_table_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Stall the result side at random
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // Search the table, then apply the request and return its result
  function automatic table_result_t predict_request(opcode_t op, logic [63:0] key);
    table_result_t r;
    int            pos;
    int            limit;
    bit            hit;
    r = '0;
    pos = 0;
    hit = 1'b0;
    limit = (model_capacity > TABLE_DEPTH) ? TABLE_DEPTH : int'(model_capacity);
    if (op != OP_NONE) begin
      for (int i = 0; i < held_keys; i++) begin
        if (!hit && stored_keys[i] == key) begin
          hit = 1'b1;
          pos = i;
        end
      end
    end
    case (op)
      OP_ADD: begin
        if (!hit) begin
          if (held_keys < limit) begin
            stored_keys[held_keys] = key;
            held_keys++;
          end else begin
            r.status = STATUS_FULL;
          end
        end
      end
      OP_REMOVE: begin
        // move the last entry into the hole
        if (hit) begin
          stored_keys[pos] = stored_keys[held_keys-1];
          held_keys--;
        end
      end
      default: begin
      end
    endcase
    r.found = hit;
    r.slot_index = pos[SLOT_FIELD_W-1:0];
    r.element_count = held_keys[COUNT_FIELD_W-1:0];
    return r;
  endfunction

  task automatic report_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Compare each result item with the oldest expectation
  always @(posedge clk) begin : result_check
    table_result_t got;
    table_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = table_result_t'(m_tdata[14:0]);
      if (pending_results.size() == 0) begin
        $display("%0t: result item with no request pending, actual %h", $time, m_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        report_field("found", want.found, got.found);
        report_field("slot_index", want.slot_index, got.slot_index);
        report_field("element_count", want.element_count, got.element_count);
        report_field("status", want.status, got.status);
      end
    end
  end

  // Offer one request item, hold it until taken, then maybe idle
  task automatic send_request(opcode_t op, logic [63:0] key);
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= key;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(predict_request(op, key));
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Drop valid and wait until every result is back
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(int index, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * index);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (index == REG_CAPACITY) model_capacity = value[CAP_FIELD_W-1:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_capacity_readback();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= 3'(4 * REG_CAPACITY);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {25'd0, model_capacity}) begin
      $display("%0t: capacity_in_use expected %0d actual %0d", $time, model_capacity,
               prdata);
      error_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_capacity(logic [31:0] value);
    wait_idle();
    write_register(REG_CAPACITY, value);
    check_capacity_readback();
  endtask

  task automatic test_register_reset();
    check_capacity_readback();
  endtask

  // Empty table, extreme keys, duplicates, swap on remove, unused opcode
  task automatic test_table_ops();
    logic [63:0] key_a;
    logic [63:0] key_b;
    key_a = 64'h0123_4567_89AB_CDEF;
    key_b = key_a ^ 64'd1;
    send_request(OP_FIND, '0);
    send_request(OP_REMOVE, 64'd5);
    send_request(OP_NONE, '1);
    send_request(OP_ADD, '0);
    send_request(OP_ADD, '1);
    send_request(OP_ADD, '0);
    send_request(OP_ADD, key_a);
    send_request(OP_ADD, key_b);
    send_request(OP_FIND, key_b);
    send_request(OP_FIND, key_a ^ 64'h8000_0000_0000_0000);
    send_request(OP_REMOVE, '0);
    send_request(OP_FIND, key_b);
    send_request(OP_REMOVE, key_b);
    send_request(OP_REMOVE, key_a);
    send_request(OP_REMOVE, '1);
    send_request(OP_REMOVE, '1);
    send_request(OP_NONE, '0);
    send_request(OP_ADD, '1);
    send_request(OP_NONE, key_a);
  endtask

  // Full table at capacity one and zero, and a write to an unused index
  task automatic test_capacity_edges();
    set_capacity(32'd1);
    send_request(OP_ADD, 64'd5);
    send_request(OP_ADD, '1);
    send_request(OP_REMOVE, '1);
    send_request(OP_ADD, 64'd5);
    set_capacity(32'd0);
    send_request(OP_ADD, 64'd7);
    send_request(OP_FIND, 64'd5);
    wait_idle();
    write_register(REG_SPARE, 32'd3);
    check_capacity_readback();
    send_request(OP_ADD, 64'd9);
    send_request(OP_REMOVE, 64'd5);
  endtask

  // Mostly requests on pool keys and held keys, some fresh random keys
  task automatic test_random_traffic(int unsigned items, int unsigned pool_size);
    opcode_t     op;
    logic [63:0] key;
    int unsigned pick;
    for (int n = 0; n < items; n++) begin
      pick = $urandom_range(99);
      if (pick < 48) op = OP_ADD;
      else if (pick < 72) op = OP_REMOVE;
      else if (pick < 95) op = OP_FIND;
      else op = OP_NONE;
      pick = $urandom_range(99);
      if (op != OP_ADD && held_keys > 0 && pick < 50) begin
        key = stored_keys[$urandom_range(held_keys - 1)];
      end else if (pick >= 92) begin
        key = {$urandom, $urandom};
      end else begin
        key = key_pool[$urandom_range(pool_size - 1)];
      end
      send_request(op, key);
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_ADD;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;

    // Random keys, extremes and near misses that differ in one bit
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i % 5 == 4) key_pool[i] = key_pool[i-1] ^ (64'd1 << $urandom_range(63));
      else key_pool[i] = {$urandom, $urandom};
    end
    key_pool[0] = '0;
    key_pool[1] = '1;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    sender_idle_pct = 8;
    receiver_idle_pct = 63;
    test_register_reset();
    test_table_ops();
    test_capacity_edges();

    set_capacity(32'd64);
    test_random_traffic(320, 80);
    set_capacity(32'd5);
    test_random_traffic(300, 12);

    wait_idle();
    sender_idle_pct = 63;
    receiver_idle_pct = 8;
    set_capacity(32'd0);
    test_random_traffic(250, 16);
    set_capacity(32'd127);
    test_random_traffic(330, 80);

    wait_idle();
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    set_capacity(32'd1);
    test_random_traffic(250, 4);
    set_capacity({25'($urandom_range(32'h1FF_FFFF)), 7'd40});
    test_random_traffic(400, 48);

    wait_idle();
    repeat (80) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
